[src/thsc_pkg.sv]
// Shared constants, types and parse helpers for the tar header stream checker.
package thsc_pkg;

   // Width of the stream position and header offset
   localparam int OFFSET_BITS = 40;

   localparam int BLOCK_BITS = 9;
   localparam int SUM_BITS   = 17;
   localparam int CSUM_BITS  = 24;
   localparam int SIZE_BITS  = 36;
   localparam int SKIP_BITS  = 37;

   // Byte offsets within a 512-byte header block
   localparam logic [BLOCK_BITS-1:0] LAST_BYTE   = 9'd511;
   localparam logic [BLOCK_BITS-1:0] SIZE_FIRST  = 9'd124;
   localparam logic [BLOCK_BITS-1:0] SIZE_LAST   = 9'd135;
   localparam logic [BLOCK_BITS-1:0] CSUM_FIRST  = 9'd148;
   localparam logic [BLOCK_BITS-1:0] CSUM_LAST   = 9'd155;
   localparam logic [BLOCK_BITS-1:0] TYPE_AT     = 9'd156;
   localparam logic [BLOCK_BITS-1:0] MAGIC_FIRST = 9'd257;
   localparam logic [BLOCK_BITS-1:0] MAGIC_LAST  = 9'd261;

   // Eight checksum bytes counted as spaces
   localparam logic [SUM_BITS-1:0] SPACES_SUM = 17'd256;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   typedef enum logic [1:0] {
      PARSE_SKIP,
      PARSE_DIGITS,
      PARSE_DONE
   } parse_phase_type;

   typedef enum logic [2:0] {
      ST_GOOD,
      ST_EMPTY,
      ST_END,
      ST_BAD_MAGIC,
      ST_BAD_SUM
   } status_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] value;
      parse_phase_type      phase;
   } octal_state_type;

   // One step of a strtol-style octal parse without sign
   function automatic octal_state_type octal_step(octal_state_type cur, logic [7:0] b);
      octal_state_type nxt;
      logic            is_digit;
      logic            is_space;
      nxt      = cur;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
      is_space = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
      case (cur.phase)
         PARSE_SKIP: begin
            if (is_digit) begin
               nxt.value = {{(SIZE_BITS-3){1'b0}}, b[2:0]};
               nxt.phase = PARSE_DIGITS;
            end else if (!is_space) begin
               nxt.phase = PARSE_DONE;
            end
         end
         PARSE_DIGITS: begin
            if (is_digit) begin
               nxt.value = {cur.value[SIZE_BITS-4:0], b[2:0]};
            end else begin
               nxt.phase = PARSE_DONE;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

   // Expected magic text "ustar"
   function automatic logic [7:0] magic_char(logic [2:0] k);
      logic [7:0] c;
      case (k)
         3'd0:    c = 8'h75;
         3'd1:    c = 8'h73;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h61;
         3'd4:    c = 8'h72;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[src/tar_header_stream_checker_unit.sv]
// Tar header stream checker: walks 512-byte blocks and reports each header.
// Takes one archive byte per beat and can accept a beat in every cycle
// while the result register has room. A beat is first captured in an input
// register; one pass then updates the per-header sums, octal parsers and
// skip counter and, on the last byte of a header block, loads the result
// register. The single-pass per-byte update sets the rate at one byte per
// cycle while results are not held off. Data blocks after a good header are
// consumed without results; after an end-of-archive or error result all
// further bytes are taken and dropped until reset.
module tar_header_stream_checker_unit (
   input  logic         clock,
   input  logic         reset,
   // input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // type_flag, file_size, header_offset,
                                     // computed_sum, stored_sum, zero fill
   output logic [2:0]   rsp_tuser    // [2:0] status
);

   localparam int OB = thsc_pkg::OFFSET_BITS;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;

   // walker state
   logic [thsc_pkg::BLOCK_BITS-1:0] idx_ff, idx_in;
   logic [thsc_pkg::SUM_BITS-1:0]   sum_ff, sum_in;
   thsc_pkg::octal_state_type       csum_ff, csum_in;
   thsc_pkg::octal_state_type       size_ff, size_in;
   logic                            magic_ok_ff, magic_ok_in;
   logic                            name_empty_ff, name_empty_in;
   logic [7:0]                      type_ff, type_in;
   logic                            prev_empty_ff, prev_empty_in;
   logic [thsc_pkg::SKIP_BITS-1:0]  skip_ff, skip_in;
   logic [OB-1:0]                   pos_ff, pos_in;
   logic                            stopped_ff, stopped_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   thsc_pkg::status_type            status_ff, status_in;
   logic [7:0]                      rtype_ff, rtype_in;
   logic [thsc_pkg::SIZE_BITS-1:0]  fsize_ff, fsize_in;
   logic [OB-1:0]                   hoff_ff, hoff_in;
   logic [thsc_pkg::SUM_BITS-1:0]   total_ff, total_in;
   logic [thsc_pkg::CSUM_BITS-1:0]  stored_ff, stored_in;

   // per-byte helpers
   thsc_pkg::octal_state_type       csum_base, size_base, csum_step, size_step;
   logic [thsc_pkg::SUM_BITS-1:0]   sum_base;
   logic [thsc_pkg::BLOCK_BITS-1:0] magic_off;
   logic [thsc_pkg::SUM_BITS-1:0]   total;
   logic [thsc_pkg::SIZE_BITS-1:0]  size_val;
   logic [thsc_pkg::SKIP_BITS-1:0]  skip_round;
   logic                            in_csum;

   // handshake: the input stage moves when the result register has room
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // helper terms for the byte in the input register
   assign in_csum   = (idx_ff >= thsc_pkg::CSUM_FIRST) && (idx_ff <= thsc_pkg::CSUM_LAST);
   assign sum_base  = (idx_ff == '0) ? '0 : sum_ff;
   assign csum_base = (idx_ff == '0) ? '{value: '0, phase: thsc_pkg::PARSE_SKIP} : csum_ff;
   assign size_base = (idx_ff == '0) ? '{value: '0, phase: thsc_pkg::PARSE_SKIP} : size_ff;
   assign csum_step = thsc_pkg::octal_step(csum_base, in_byte_ff);
   assign size_step = thsc_pkg::octal_step(size_base, in_byte_ff);
   assign magic_off = idx_ff - thsc_pkg::MAGIC_FIRST;
   assign size_val  = size_ff.value;
   assign skip_round = {size_val[thsc_pkg::SIZE_BITS-1:thsc_pkg::BLOCK_BITS]
                        + {{(thsc_pkg::SIZE_BITS-thsc_pkg::BLOCK_BITS-1){1'b0}},
                           (size_val[thsc_pkg::BLOCK_BITS-1:0] != '0)},
                        {thsc_pkg::BLOCK_BITS{1'b0}}};

   // next state and result for one byte
   always_comb begin
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      csum_in       = csum_ff;
      size_in       = size_ff;
      magic_ok_in   = magic_ok_ff;
      name_empty_in = name_empty_ff;
      type_in       = type_ff;
      prev_empty_in = prev_empty_ff;
      skip_in       = skip_ff;
      pos_in        = pos_ff;
      stopped_in    = stopped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      status_in     = status_ff;
      rtype_in      = rtype_ff;
      fsize_in      = fsize_ff;
      hoff_in       = hoff_ff;
      total_in      = total_ff;
      stored_in     = stored_ff;
      total         = '0;

      if (in_valid_ff && advance && !stopped_ff) begin
         pos_in = pos_ff + OB'(1);
         if (skip_ff != '0) begin
            skip_in = skip_ff - thsc_pkg::SKIP_BITS'(1);
         end else begin
            // start of a header clears the accumulators
            if (idx_ff == '0) begin
               csum_in       = csum_base;
               size_in       = size_base;
               magic_ok_in   = 1'b1;
               type_in       = '0;
               name_empty_in = (in_byte_ff == '0);
            end
            sum_in = in_csum ? sum_base
                             : sum_base + {{(thsc_pkg::SUM_BITS-8){1'b0}}, in_byte_ff};
            if ((idx_ff >= thsc_pkg::SIZE_FIRST) && (idx_ff <= thsc_pkg::SIZE_LAST)) begin
               size_in = size_step;
            end
            if (in_csum) begin
               csum_in = '{value: {{(thsc_pkg::SIZE_BITS-thsc_pkg::CSUM_BITS){1'b0}},
                                  csum_step.value[thsc_pkg::CSUM_BITS-1:0]},
                           phase: csum_step.phase};
            end
            if (idx_ff == thsc_pkg::TYPE_AT) begin
               type_in = in_byte_ff;
            end
            if ((idx_ff >= thsc_pkg::MAGIC_FIRST) && (idx_ff <= thsc_pkg::MAGIC_LAST)) begin
               if (in_byte_ff != thsc_pkg::magic_char(magic_off[2:0])) begin
                  magic_ok_in = 1'b0;
               end
            end
            idx_in = idx_ff + thsc_pkg::BLOCK_BITS'(1);

            // last byte of the header: build the result
            if (idx_ff == thsc_pkg::LAST_BYTE) begin
               total        = sum_in + thsc_pkg::SPACES_SUM;
               rsp_valid_in = 1'b1;
               rtype_in     = type_ff;
               fsize_in     = '0;
               hoff_in      = pos_ff - OB'(thsc_pkg::LAST_BYTE);
               total_in     = total;
               stored_in    = csum_ff.value[thsc_pkg::CSUM_BITS-1:0];
               if (name_empty_ff) begin
                  if (prev_empty_ff) begin
                     status_in  = thsc_pkg::ST_END;
                     stopped_in = 1'b1;
                  end else begin
                     status_in     = thsc_pkg::ST_EMPTY;
                     prev_empty_in = 1'b1;
                  end
               end else begin
                  prev_empty_in = 1'b0;
                  if (!magic_ok_ff) begin
                     status_in  = thsc_pkg::ST_BAD_MAGIC;
                     stopped_in = 1'b1;
                  end else if ({{(thsc_pkg::CSUM_BITS-thsc_pkg::SUM_BITS){1'b0}}, total}
                               != csum_ff.value[thsc_pkg::CSUM_BITS-1:0]) begin
                     status_in  = thsc_pkg::ST_BAD_SUM;
                     stopped_in = 1'b1;
                  end else begin
                     status_in = thsc_pkg::ST_GOOD;
                     fsize_in  = size_val;
                     skip_in   = skip_round;
                  end
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         sum_ff        <= '0;
         csum_ff       <= '{value: '0, phase: thsc_pkg::PARSE_SKIP};
         size_ff       <= '{value: '0, phase: thsc_pkg::PARSE_SKIP};
         magic_ok_ff   <= 1'b1;
         name_empty_ff <= 1'b0;
         type_ff       <= '0;
         prev_empty_ff <= 1'b0;
         skip_ff       <= '0;
         pos_ff        <= '0;
         stopped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         sum_ff        <= sum_in;
         csum_ff       <= csum_in;
         size_ff       <= size_in;
         magic_ok_ff   <= magic_ok_in;
         name_empty_ff <= name_empty_in;
         type_ff       <= type_in;
         prev_empty_ff <= prev_empty_in;
         skip_ff       <= skip_in;
         pos_ff        <= pos_in;
         stopped_ff    <= stopped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rtype_ff  <= rtype_in;
      fsize_ff  <= fsize_in;
      hoff_ff   <= hoff_in;
      total_ff  <= total_in;
      stored_ff <= stored_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, stored_ff, total_ff, hoff_ff, fsize_ff, rtype_ff};

endmodule

[sim/tar_header_stream_checker_unit_tb.sv]
// Self-checking testbench for the tar header stream checker: tar archive beats in, header reports out.
`timescale 1ns / 1ps

module tar_header_stream_checker_unit_tb;
   import thsc_pkg::*;

   localparam int  DRAIN_CYCLES = 8;
   localparam int  HOLD_CYCLES  = 2500;
   localparam time RUN_LIMIT_NS = 10_000_000;

   localparam logic [39:0] USTAR_TEXT = "ustar";

   // Ways the archive is brought to a halt at the end of the run
   localparam int HALT_BY_END   = 0;
   localparam int HALT_BY_MAGIC = 1;
   localparam int HALT_BY_SUM   = 2;

   // How an octal header field is laid out
   typedef enum int {
      FMT_PADDED,
      FMT_SPACED,
      FMT_FULL,
      FMT_NO_DIGITS,
      FMT_BLANK
   } octal_format_type;

   typedef struct {
      status_type             status;
      logic [7:0]             type_flag;
      logic [SIZE_BITS-1:0]   file_size;
      logic [OFFSET_BITS-1:0] header_offset;
      logic [SUM_BITS-1:0]    computed_sum;
      logic [CSUM_BITS-1:0]   stored_sum;
   } header_report_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;  // [7:0] data_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;            // type_flag, file_size, header_offset,
                                       // computed_sum, stored_sum, zero fill
   logic [2:0]   rsp_tuser;            // [2:0] status

   // Header reports still owed by the block, oldest first
   header_report_type pending_reports[$];
   int error_count       = 0;
   int reports_predicted = 0;

   // Idle and stall rates, percent of cycles
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   // Long hold-off: requests counted here, served by the ready process
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   // Header block under construction
   logic [7:0] hdr_img [0:511];

   // Archive walker state
   logic [BLOCK_BITS-1:0]  blk_pos        = '0;
   logic [SUM_BITS-1:0]    hdr_sum        = '0;
   logic [SIZE_BITS-1:0]   size_acc       = '0;
   parse_phase_type        size_phase     = PARSE_SKIP;
   logic [SIZE_BITS-1:0]   csum_acc       = '0;
   parse_phase_type        csum_phase     = PARSE_SKIP;
   logic                   magic_good     = 1'b1;
   logic                   name_zero      = 1'b0;
   logic [7:0]             type_seen      = 8'h00;
   logic                   last_was_empty = 1'b0;
   logic [SKIP_BITS-1:0]   data_left      = '0;
   logic [OFFSET_BITS-1:0] byte_count     = '0;
   logic                   halted         = 1'b0;

   tar_header_stream_checker_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // One strtol-like octal step, no sign, value kept to nbits
   task automatic octal_parse_step(inout logic [SIZE_BITS-1:0] acc, inout parse_phase_type ph,
                                   input logic [7:0] b, input int nbits);
      logic                 digit;
      logic                 blank;
      logic [SIZE_BITS-1:0] keep;
      digit = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
      blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
      keep  = {SIZE_BITS{1'b1}} >> (SIZE_BITS - nbits);
      case (ph)
         PARSE_SKIP: begin
            if (digit) begin
               acc = {{(SIZE_BITS-3){1'b0}}, b[2:0]};
               ph  = PARSE_DIGITS;
            end else if (!blank) begin
               ph = PARSE_DONE;
            end
         end
         PARSE_DIGITS: begin
            if (digit) begin
               acc = ((acc << 3) | {{(SIZE_BITS-3){1'b0}}, b[2:0]}) & keep;
            end else begin
               ph = PARSE_DONE;
            end
         end
         default: begin
         end
      endcase
   endtask

   // Walk one accepted archive byte; queue a report at the end of a header block
   task automatic track_archive_byte(input logic [7:0] b);
      header_report_type      r;
      logic [OFFSET_BITS-1:0] here;
      logic [SUM_BITS-1:0]    total;
      logic [63:0]            rounded;
      if (halted) return;
      here       = byte_count;
      byte_count = byte_count + 1'b1;
      if (data_left != 0) begin
         data_left = data_left - 1'b1;
         return;
      end
      if (blk_pos == 0) begin
         hdr_sum    = '0;
         size_acc   = '0;
         size_phase = PARSE_SKIP;
         csum_acc   = '0;
         csum_phase = PARSE_SKIP;
         magic_good = 1'b1;
         type_seen  = 8'h00;
         name_zero  = (b == 8'h00);
      end
      if (blk_pos < CSUM_FIRST || blk_pos > CSUM_LAST) hdr_sum = hdr_sum + b;
      if (blk_pos >= SIZE_FIRST && blk_pos <= SIZE_LAST)
         octal_parse_step(size_acc, size_phase, b, SIZE_BITS);
      if (blk_pos >= CSUM_FIRST && blk_pos <= CSUM_LAST)
         octal_parse_step(csum_acc, csum_phase, b, CSUM_BITS);
      if (blk_pos == TYPE_AT) type_seen = b;
      if (blk_pos >= MAGIC_FIRST && blk_pos <= MAGIC_LAST)
         if (b != USTAR_TEXT[8*(MAGIC_LAST - blk_pos) +: 8]) magic_good = 1'b0;
      if (blk_pos != LAST_BYTE) begin
         blk_pos = blk_pos + 1'b1;
         return;
      end
      blk_pos = '0;

      // last byte of the header: decide the report
      total           = hdr_sum + SPACES_SUM;
      r.type_flag     = type_seen;
      r.file_size     = '0;
      r.header_offset = here - LAST_BYTE;
      r.computed_sum  = total;
      r.stored_sum    = csum_acc[CSUM_BITS-1:0];
      if (name_zero) begin
         if (last_was_empty) begin
            r.status = ST_END;
            halted   = 1'b1;
         end else begin
            r.status       = ST_EMPTY;
            last_was_empty = 1'b1;
         end
      end else begin
         last_was_empty = 1'b0;
         if (!magic_good) begin
            r.status = ST_BAD_MAGIC;
            halted   = 1'b1;
         end else if ({{(CSUM_BITS-SUM_BITS){1'b0}}, total} != csum_acc[CSUM_BITS-1:0]) begin
            r.status = ST_BAD_SUM;
            halted   = 1'b1;
         end else begin
            r.status    = ST_GOOD;
            r.file_size = size_acc;
            rounded     = ((64'(size_acc) + 64'd511) / 64'd512) * 64'd512;
            data_left   = rounded[SKIP_BITS-1:0];
         end
      end
      pending_reports.push_back(r);
      reports_predicted++;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Compare one result beat against the oldest owed report
   task automatic check_report();
      header_report_type want;
      if (pending_reports.size() == 0) begin
         report_mismatch("result with none owed, status", rsp_tuser, 0);
         return;
      end
      want = pending_reports.pop_front();
      if (rsp_tuser !== want.status) report_mismatch("status", rsp_tuser, want.status);
      if (rsp_tdata[7:0] !== want.type_flag)
         report_mismatch("type_flag", rsp_tdata[7:0], want.type_flag);
      if (rsp_tdata[43:8] !== want.file_size)
         report_mismatch("file_size", rsp_tdata[43:8], want.file_size);
      if (rsp_tdata[83:44] !== want.header_offset)
         report_mismatch("header_offset", rsp_tdata[83:44], want.header_offset);
      if (rsp_tdata[100:84] !== want.computed_sum)
         report_mismatch("computed_sum", rsp_tdata[100:84], want.computed_sum);
      if (rsp_tdata[124:101] !== want.stored_sum)
         report_mismatch("stored_sum", rsp_tdata[124:101], want.stored_sum);
      if (rsp_tdata[127:125] !== 3'b000)
         report_mismatch("tdata fill", rsp_tdata[127:125], 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_report();
   end

   // Result side ready: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen  <= hold_requests;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Send one byte beat; starts and ends at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_archive_byte(b);
      @(negedge clock);
   endtask

   // Stop sending and let every owed report come out
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CHAR_SPACE : CHAR_TAB + k;
   endfunction

   function automatic logic [7:0] pick_non_octal();
      logic [7:0] t;
      do t = $urandom_range(0, 255); while (t >= CHAR_ZERO && t <= CHAR_SEVEN);
      return t;
   endfunction

   // Write an octal field into the header image in the given layout
   task automatic put_octal(input int first, input int len, input logic [35:0] value,
                            input octal_format_type fmt);
      int          ndig;
      int          lead;
      int          wid;
      int          p;
      int          k;
      logic [35:0] v;
      logic [7:0]  stop;
      ndig = 1;
      v    = value >> 3;
      while (v != 0) begin
         ndig++;
         v = v >> 3;
      end
      lead = 0;
      wid  = ndig;
      stop = pick_non_octal();
      case (fmt)
         FMT_PADDED: begin
            wid  = len - 1;
            stop = 8'h00;
         end
         FMT_SPACED: begin
            lead = $urandom_range(0, len - ndig - 1);
         end
         FMT_FULL: begin
            wid = len;
         end
         FMT_NO_DIGITS: begin
            // a sign or other stopper before any digit parses as zero
            wid  = 0;
            lead = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
               0:       stop = "+";
               1:       stop = "-";
               2:       stop = 8'h00;
               default: stop = "9";
            endcase
         end
         default: begin
            wid  = 0;
            lead = len;
         end
      endcase
      for (k = 0; k < lead; k++) hdr_img[first + k] = pick_blank();
      v = value;
      for (k = wid - 1; k >= 0; k--) begin
         hdr_img[first + lead + k] = CHAR_ZERO | {5'b00000, v[2:0]};
         v = v >> 3;
      end
      p = first + lead + wid;
      if (p < first + len) hdr_img[p] = stop;
      for (k = p + 1; k < first + len; k++) hdr_img[k] = $urandom_range(0, 255);
   endtask

   // Fill the header image: random body, size, type, magic and checksum fields
   task automatic build_header(input bit empty, input logic [35:0] size,
                               input octal_format_type size_fmt,
                               input octal_format_type sum_fmt,
                               input bit bad_magic, input bit bad_sum,
                               input logic [7:0] tflag);
      int                  k;
      int                  fill;
      logic [SUM_BITS-1:0] total;
      logic [23:0]         stored;
      fill = $urandom_range(0, 2);
      for (k = 0; k < 512; k++) begin
         case (fill)
            0:       hdr_img[k] = 8'h00;
            1:       hdr_img[k] = $urandom_range(32, 126);
            default: hdr_img[k] = $urandom_range(0, 255);
         endcase
      end
      hdr_img[0] = empty ? 8'h00 : 8'($urandom_range(1, 255));
      put_octal(SIZE_FIRST, 12, size, size_fmt);
      // a digit right after a full size field must not extend it
      if (size_fmt == FMT_FULL) hdr_img[SIZE_LAST + 1] = CHAR_ZERO + $urandom_range(0, 7);
      hdr_img[TYPE_AT] = tflag;
      for (k = 0; k < 5; k++) hdr_img[MAGIC_FIRST + k] = USTAR_TEXT[8*(4-k) +: 8];
      if (bad_magic) begin
         k = $urandom_range(0, 4);
         hdr_img[MAGIC_FIRST + k] = hdr_img[MAGIC_FIRST + k] ^ 8'($urandom_range(1, 255));
      end
      // checksum field counts as spaces, so the sum is known before it is written
      total = SPACES_SUM;
      for (k = 0; k < 512; k++)
         if (k < CSUM_FIRST || k > CSUM_LAST) total = total + hdr_img[k];
      stored = bad_sum ? total + $urandom_range(1, 4000) : total;
      put_octal(CSUM_FIRST, 8, stored, sum_fmt);
   endtask

   task automatic send_header_block();
      int k;
      for (k = 0; k < 512; k++) send_byte(hdr_img[k]);
   endtask

   task automatic send_good_file(input logic [35:0] size, input octal_format_type size_fmt,
                                 input octal_format_type sum_fmt, input logic [7:0] tflag);
      int k;
      int nbytes;
      build_header(1'b0, size, size_fmt, sum_fmt, 1'b0, 1'b0, tflag);
      send_header_block();
      nbytes = ((int'(size) + 511) / 512) * 512;
      for (k = 0; k < nbytes; k++) send_byte($urandom_range(0, 255));
   endtask

   // Empty header with arbitrary content elsewhere; never skips data
   task automatic send_empty_header();
      build_header(1'b1, $urandom_range(0, 4000), FMT_PADDED, FMT_PADDED,
                   $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255));
      send_header_block();
   endtask

   function automatic logic [35:0] pick_file_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 0;
      if (r < 35) return 512 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
      if (r < 95) return $urandom_range(1, 1200);
      return $urandom_range(1201, 4000);
   endfunction

   // Field layouts, size and type flag extremes, spill past a full field
   task automatic test_octal_fields();
      sender_idle_pct = 8;
      rsp_stall_pct   = 8;
      send_good_file(0, FMT_NO_DIGITS, FMT_PADDED, 8'h00);
      send_good_file(0, FMT_BLANK, FMT_SPACED, 8'hff);
      send_good_file(1, FMT_SPACED, FMT_FULL, "0");
      send_good_file(511, FMT_FULL, FMT_SPACED, "5");
      send_good_file(512, FMT_SPACED, FMT_PADDED, "0");
      send_good_file(513, FMT_PADDED, FMT_FULL, $urandom_range(0, 255));
      wait_drain();
   endtask

   // Single empty headers between files
   task automatic test_empty_headers();
      sender_idle_pct = 8;
      rsp_stall_pct   = 8;
      send_empty_header();
      send_good_file(100, FMT_SPACED, FMT_PADDED, "0");
      send_empty_header();
      send_good_file(0, FMT_PADDED, FMT_SPACED, "5");
      wait_drain();
   endtask

   // Well-formed archive with random content and layouts
   task automatic test_random_archive(input int idle_pct, input int stall_pct,
                                      input int n_reports);
      int               target;
      logic [35:0]      sz;
      octal_format_type sfmt;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      target          = reports_predicted + n_reports;
      while (reports_predicted < target) begin
         if ($urandom_range(0, 99) < 12 && !last_was_empty) begin
            send_empty_header();
         end else begin
            sz   = pick_file_size();
            sfmt = (sz == 0) ? octal_format_type'($urandom_range(0, 4))
                             : octal_format_type'($urandom_range(0, 2));
            send_good_file(sz, sfmt, octal_format_type'($urandom_range(0, 2)),
                           ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255)) : "0");
         end
      end
      wait_drain();
   endtask

   // Result side held off while headers keep coming, so the input stalls
   task automatic test_back_pressure();
      int k;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      hold_requests++;
      for (k = 0; k < 6; k++) send_good_file(0, FMT_PADDED, FMT_PADDED, "0");
      wait_drain();
   endtask

   // End of archive or an error halts the block; later bytes are dropped
   task automatic test_halting();
      int k;
      sender_idle_pct = 8;
      rsp_stall_pct   = 8;
      case ($urandom_range(HALT_BY_END, HALT_BY_SUM))
         HALT_BY_END: begin
            send_empty_header();
            send_empty_header();
         end
         HALT_BY_MAGIC: begin
            // bad magic wins over a bad checksum
            build_header(1'b0, $urandom_range(0, 4000), FMT_PADDED, FMT_PADDED, 1'b1,
                         $urandom_range(0, 1), $urandom_range(0, 255));
            send_header_block();
         end
         default: begin
            build_header(1'b0, $urandom_range(0, 4000), FMT_SPACED,
                         octal_format_type'($urandom_range(0, 4)), 1'b0, 1'b1,
                         $urandom_range(0, 255));
            send_header_block();
         end
      endcase
      for (k = 0; k < 700; k++) send_byte($urandom_range(0, 255));
      wait_drain();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_octal_fields();
      test_empty_headers();
      test_random_archive(0, 0, 12);
      test_random_archive(64, 0, 12);
      test_random_archive(0, 64, 12);
      test_random_archive(8, 8, 12);
      test_back_pressure();
      test_halting();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
